// ===== design/dsr_pkg.sv =====
`timescale 1ns / 1ps

package dsr_pkg;

    typedef struct packed {
        logic [3:0]         motor_index;
        logic [15:0]        status_word;
        logic signed [31:0] measured_position;
        logic signed [31:0] host_target;
        logic               link_operational;
        logic               cycle_end;
    } frame_t;

    typedef struct packed {
        logic [15:0]        control_word;
        logic signed [31:0] command_position;
        logic               position_valid;
        logic               target_reseed;
        logic               all_came_up;
        logic               link_lost;
    } result_t;

    typedef struct packed {
        logic [15:0] control_word;
        logic [31:0] command;
        logic        position_valid;
        logic        target_reseed;
        logic        held_we;
        logic [31:0] held_next;
        logic        first_we;
        logic        first_next;
    } drive_res_t;

    typedef struct packed {
        logic advance;
        logic in_range;
        logic link_ok;
        logic cycle_end;
    } link_ctl_t;

    typedef struct packed {
        logic lost;
        logic done_next;
        logic lost_next;
    } link_stat_t;

    localparam logic [1:0] CFG_RAMP_STEP_LARGE   = 2'd0;
    localparam logic [1:0] CFG_RAMP_STEP_SMALL   = 2'd1;
    localparam logic [1:0] CFG_LARGE_GROUP_COUNT = 2'd2;

    localparam logic [15:0] RESET_STEP_LARGE  = 16'd50;
    localparam logic [15:0] RESET_STEP_SMALL  = 16'd25;
    localparam logic [4:0]  RESET_GROUP_COUNT = 5'd4;

    localparam logic [15:0] STATUS_MASK    = 16'h006F;
    localparam logic [15:0] ST_FAULT       = 16'h0008;
    localparam logic [15:0] ST_DISABLED    = 16'h0040;
    localparam logic [15:0] ST_READY       = 16'h0021;
    localparam logic [15:0] ST_SWITCHED_ON = 16'h0023;
    localparam logic [15:0] ST_OP_ENABLED  = 16'h0027;

    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

    localparam logic [4:0] COUNT_MAX = 5'd31;

endpackage

// ===== design/dsr_drive.sv =====
`timescale 1ns / 1ps

module dsr_drive
(
    input  logic [15:0]       status_word,
    input  logic [31:0]       measured_position,
    input  logic [31:0]       host_target,
    input  logic [31:0]       held,
    input  logic              first,
    input  logic [15:0]       step,
    output dsr_pkg::drive_res_t res
);

    logic [15:0]        state;
    logic signed [32:0] cur_ext;
    logic signed [32:0] tgt_ext;
    logic signed [32:0] diff;
    logic signed [32:0] step_ext;
    logic signed [32:0] next_ext;

    assign state    = status_word & dsr_pkg::STATUS_MASK;
    assign cur_ext  = $signed({held[31], held});
    assign tgt_ext  = $signed({host_target[31], host_target});
    assign diff     = tgt_ext - cur_ext;
    assign step_ext = $signed({17'd0, step});

    always_comb
    begin
        if (diff > step_ext)
        begin
            next_ext = cur_ext + step_ext;
        end
        else if (diff < -step_ext)
        begin
            next_ext = cur_ext - step_ext;
        end
        else
        begin
            next_ext = tgt_ext;
        end
    end

    always_comb
    begin
        res                = '0;
        res.control_word   = dsr_pkg::CW_SHUTDOWN;
        res.command        = held;
        res.held_next      = held;
        res.first_next     = first;
        unique case (state)
            dsr_pkg::ST_FAULT, dsr_pkg::ST_DISABLED,
            dsr_pkg::ST_READY, dsr_pkg::ST_SWITCHED_ON:
            begin
                if (state == dsr_pkg::ST_FAULT)
                begin
                    res.control_word = dsr_pkg::CW_FAULT_RESET;
                end
                else if (state == dsr_pkg::ST_READY)
                begin
                    res.control_word = dsr_pkg::CW_SWITCH_ON;
                end
                else if (state == dsr_pkg::ST_SWITCHED_ON)
                begin
                    res.control_word = dsr_pkg::CW_ENABLE_OP;
                end
                else
                begin
                    res.control_word = dsr_pkg::CW_SHUTDOWN;
                end
                res.held_we        = 1'b1;
                res.held_next      = measured_position;
                res.first_we       = 1'b1;
                res.first_next     = 1'b1;
                res.command        = measured_position;
                res.position_valid = 1'b1;
            end
            dsr_pkg::ST_OP_ENABLED:
            begin
                res.control_word   = dsr_pkg::CW_ENABLE_OP;
                res.position_valid = 1'b1;
                if (first)
                begin
                    res.first_we      = 1'b1;
                    res.first_next    = 1'b0;
                    res.target_reseed = 1'b1;
                end
                else
                begin
                    res.held_we   = 1'b1;
                    res.held_next = next_ext[31:0];
                    res.command   = next_ext[31:0];
                end
            end
            default:
            begin
                res.control_word = dsr_pkg::CW_SHUTDOWN;
            end
        endcase
    end

endmodule

// ===== design/dsr_link_mon.sv =====
`timescale 1ns / 1ps

module dsr_link_mon
#(
    parameter int MOTOR_COUNT = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dsr_pkg::link_ctl_t  ctl,
    output dsr_pkg::link_stat_t stat
);

    localparam logic [4:0] MOTORS = 5'(MOTOR_COUNT);

    logic [4:0] count_reg;
    logic [4:0] count_next;
    logic [4:0] count_inc;
    logic       done_reg;
    logic       done_next;
    logic       lost_reg;
    logic       lost_next;

    always_comb
    begin
        if (ctl.in_range && ctl.link_ok && count_reg != dsr_pkg::COUNT_MAX)
        begin
            count_inc = count_reg + 5'd1;
        end
        else
        begin
            count_inc = count_reg;
        end
        count_next = count_inc;
        done_next  = done_reg;
        lost_next  = lost_reg;
        if (ctl.cycle_end)
        begin
            count_next = '0;
            if (!done_reg)
            begin
                done_next = (count_inc == MOTORS);
            end
            else if (count_inc != MOTORS)
            begin
                lost_next = 1'b1;
            end
        end
        if (lost_reg)
        begin
            count_next = count_reg;
            done_next  = done_reg;
            lost_next  = lost_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            lost_reg  <= 1'b0;
        end
        else if (ctl.advance)
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            lost_reg  <= lost_next;
        end
    end

    assign stat.lost      = lost_reg;
    assign stat.done_next = done_next;
    assign stat.lost_next = lost_next;

endmodule

// ===== design/drive_enable_sequencer_with_ramp.sv =====
`timescale 1ns / 1ps

// Drive enable sequencer with a ramped position command, one motor frame per beat.
// A frame beat on frame_valid/frame_ready carries one motor's status, position,
// host target and link state; the block answers each frame with exactly one
// result beat on result_valid/result_ready, in order.
// A frame is held in an input register, decoded and ramped in one pass, and the
// answer lands in a result register, which drives result_valid. Throughput is one
// frame per cycle while the receiver takes results; the per-motor command and
// enable state are read and written in that single pass, which lets frames for
// the same motor follow each other directly.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more frame; after that frame_ready drops until
// the result is taken.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready and should be written only while no frame is in flight.
// Reset clears the held commands to zero, marks every motor for a fresh enable,
// clears the link count, bring-up and loss flags, and restores ramp steps of 50
// and 25 with four motors in the large group.
module drive_enable_sequencer_with_ramp
#(
    parameter int MOTOR_COUNT = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_ready,
    input  dsr_pkg::frame_t  frame,
    output logic             result_valid,
    input  logic             result_ready,
    output dsr_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam logic [4:0] MOTORS = 5'(MOTOR_COUNT);

    logic [15:0] step_large_reg;
    logic [15:0] step_small_reg;
    logic [4:0]  group_count_reg;

    dsr_pkg::frame_t  frame_reg;
    logic             frame_valid_reg;
    dsr_pkg::result_t result_reg;
    dsr_pkg::result_t result_next;
    logic             result_valid_reg;

    logic [31:0]      held_reg [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] first_reg;

    logic             out_load;
    logic             advance;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [31:0]      held_cur;
    logic             first_cur;
    logic [15:0]      step;

    dsr_pkg::drive_res_t drive_res;
    dsr_pkg::link_ctl_t  link_ctl;
    dsr_pkg::link_stat_t link_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_large_reg  <= dsr_pkg::RESET_STEP_LARGE;
            step_small_reg  <= dsr_pkg::RESET_STEP_SMALL;
            group_count_reg <= dsr_pkg::RESET_GROUP_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsr_pkg::CFG_RAMP_STEP_LARGE:   step_large_reg  <= cfg_data;
                dsr_pkg::CFG_RAMP_STEP_SMALL:   step_small_reg  <= cfg_data;
                dsr_pkg::CFG_LARGE_GROUP_COUNT: group_count_reg <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_load    = !result_valid_reg || result_ready;
    assign advance     = frame_valid_reg && out_load;
    assign frame_ready = !frame_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else if (frame_ready)
        begin
            frame_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            frame_reg <= frame;
        end
    end

    assign in_range  = ({1'b0, frame_reg.motor_index} < MOTORS);
    assign idx       = frame_reg.motor_index[IDX_W-1:0];
    assign held_cur  = held_reg[idx];
    assign first_cur = first_reg[idx];
    assign step      = ({1'b0, frame_reg.motor_index} < group_count_reg)
                       ? step_large_reg : step_small_reg;

    dsr_drive u_drive
    (
        .status_word       (frame_reg.status_word),
        .measured_position (frame_reg.measured_position),
        .host_target       (frame_reg.host_target),
        .held              (held_cur),
        .first             (first_cur),
        .step              (step),
        .res               (drive_res)
    );

    assign link_ctl.advance   = advance;
    assign link_ctl.in_range  = in_range;
    assign link_ctl.link_ok   = frame_reg.link_operational;
    assign link_ctl.cycle_end = frame_reg.cycle_end;

    dsr_link_mon #(.MOTOR_COUNT(MOTOR_COUNT)) u_link_mon
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (link_ctl),
        .stat  (link_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                held_reg[i] <= '0;
            end
            first_reg <= '1;
        end
        else if (advance && in_range && !link_stat.lost)
        begin
            if (drive_res.held_we)
            begin
                held_reg[idx] <= drive_res.held_next;
            end
            if (drive_res.first_we)
            begin
                first_reg[idx] <= drive_res.first_next;
            end
        end
    end

    always_comb
    begin
        result_next.control_word     = dsr_pkg::CW_SHUTDOWN;
        result_next.command_position = '0;
        result_next.position_valid   = 1'b0;
        result_next.target_reseed    = 1'b0;
        result_next.all_came_up      = link_stat.done_next;
        result_next.link_lost        = link_stat.lost_next;
        if (!link_stat.lost && in_range)
        begin
            result_next.control_word     = drive_res.control_word;
            result_next.command_position = drive_res.command;
            result_next.position_valid   = drive_res.position_valid;
            result_next.target_reseed    = drive_res.target_reseed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= frame_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Once a link loss is latched it stays latched until reset.
    a_lost_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        link_stat.lost |=> link_stat.lost)
        else $error("link loss latch cleared without reset");

    // A loss can only be latched after bring-up has completed.
    a_lost_after_bringup: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.link_lost) |-> result.all_came_up)
        else $error("link loss reported before bring-up");

    // A reseed request always comes with an enable-operation command word.
    a_reseed_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.target_reseed) |->
            (result.position_valid && result.control_word == dsr_pkg::CW_ENABLE_OP))
        else $error("reseed without enable operation");

    // After a loss, no further position commands are issued.
    a_no_cmd_after_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && link_stat.lost) |=> !result.position_valid)
        else $error("position command issued after link loss");

endmodule

// ===== tb/drive_enable_sequencer_with_ramp_checker.sv =====
`timescale 1ns / 1ps

module drive_enable_sequencer_with_ramp_checker
#(
    parameter int MOTOR_COUNT = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    input  logic             frame_ready,
    input  dsr_pkg::frame_t  frame,
    input  logic             result_valid,
    input  logic             result_ready,
    input  dsr_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output int               fail_count,
    output int               outstanding
);

    logic [15:0]        step_large;
    logic [15:0]        step_small;
    logic [4:0]         group_count;
    logic signed [31:0] held_cmd [MOTOR_COUNT];
    logic               fresh_enable [MOTOR_COUNT];
    logic [4:0]         link_tally;
    logic               brought_up;
    logic               lost_latched;
    dsr_pkg::result_t   pending_answers [$];
    int                 mismatch_total = 0;

    assign fail_count = mismatch_total;

    task automatic clear_drive_state();
        step_large   = dsr_pkg::RESET_STEP_LARGE;
        step_small   = dsr_pkg::RESET_STEP_SMALL;
        group_count  = dsr_pkg::RESET_GROUP_COUNT;
        link_tally   = '0;
        brought_up   = 1'b0;
        lost_latched = 1'b0;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            held_cmd[m]     = '0;
            fresh_enable[m] = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string line);
        $display("[%0t] mismatch: %s", $time, line);
        mismatch_total++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    function automatic dsr_pkg::result_t next_drive_answer(input dsr_pkg::frame_t f);
        dsr_pkg::result_t r;
        logic [15:0]      state;
        longint           limit;
        longint           cur;
        longint           goal;
        longint           gap;
        longint           nxt;
        int               idx;
        r = '0;
        r.control_word = dsr_pkg::CW_SHUTDOWN;
        if (lost_latched)
        begin
            r.all_came_up = brought_up;
            r.link_lost   = 1'b1;
            return r;
        end
        idx   = int'(f.motor_index);
        state = f.status_word & dsr_pkg::STATUS_MASK;
        if (idx < MOTOR_COUNT)
        begin
            if (f.link_operational && link_tally < dsr_pkg::COUNT_MAX)
            begin
                link_tally++;
            end
            case (state)
                dsr_pkg::ST_FAULT, dsr_pkg::ST_DISABLED,
                dsr_pkg::ST_READY, dsr_pkg::ST_SWITCHED_ON:
                begin
                    if (state == dsr_pkg::ST_FAULT)
                        r.control_word = dsr_pkg::CW_FAULT_RESET;
                    else if (state == dsr_pkg::ST_DISABLED)
                        r.control_word = dsr_pkg::CW_SHUTDOWN;
                    else if (state == dsr_pkg::ST_READY)
                        r.control_word = dsr_pkg::CW_SWITCH_ON;
                    else
                        r.control_word = dsr_pkg::CW_ENABLE_OP;
                    held_cmd[idx]     = f.measured_position;
                    fresh_enable[idx] = 1'b1;
                    r.position_valid  = 1'b1;
                end
                dsr_pkg::ST_OP_ENABLED:
                begin
                    if (fresh_enable[idx])
                    begin
                        fresh_enable[idx] = 1'b0;
                        r.target_reseed   = 1'b1;
                    end
                    else
                    begin
                        limit = (idx < group_count) ? longint'(step_large)
                                                    : longint'(step_small);
                        cur   = longint'(held_cmd[idx]);
                        goal  = longint'(f.host_target);
                        gap   = goal - cur;
                        if (gap > limit)
                            nxt = cur + limit;
                        else if (gap < -limit)
                            nxt = cur - limit;
                        else
                            nxt = goal;
                        held_cmd[idx] = nxt[31:0];
                    end
                    r.control_word   = dsr_pkg::CW_ENABLE_OP;
                    r.position_valid = 1'b1;
                end
                default:
                begin
                    r.control_word = dsr_pkg::CW_SHUTDOWN;
                end
            endcase
            r.command_position = held_cmd[idx];
        end
        if (f.cycle_end)
        begin
            if (!brought_up)
            begin
                if (link_tally == MOTOR_COUNT)
                    brought_up = 1'b1;
            end
            else if (link_tally != MOTOR_COUNT)
            begin
                lost_latched = 1'b1;
            end
            link_tally = '0;
        end
        r.all_came_up = brought_up;
        r.link_lost   = lost_latched;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        dsr_pkg::result_t want;
        dsr_pkg::result_t answer;
        if (!rst_n)
        begin
            clear_drive_state();
            pending_answers.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dsr_pkg::CFG_RAMP_STEP_LARGE:   step_large  = cfg_data;
                    dsr_pkg::CFG_RAMP_STEP_SMALL:   step_small  = cfg_data;
                    dsr_pkg::CFG_LARGE_GROUP_COUNT: group_count = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    report_mismatch("result beat with no frame waiting for it");
                end
                else
                begin
                    want = pending_answers.pop_front();
                    compare_field("control_word", 32'(result.control_word),
                                  32'(want.control_word));
                    compare_field("command_position", result.command_position,
                                  want.command_position);
                    compare_field("position_valid", 32'(result.position_valid),
                                  32'(want.position_valid));
                    compare_field("target_reseed", 32'(result.target_reseed),
                                  32'(want.target_reseed));
                    compare_field("all_came_up", 32'(result.all_came_up),
                                  32'(want.all_came_up));
                    compare_field("link_lost", 32'(result.link_lost),
                                  32'(want.link_lost));
                end
            end
            if (frame_valid && frame_ready)
            begin
                answer          = next_drive_answer(frame);
                pending_answers = {pending_answers, answer};
            end
            outstanding <= pending_answers.size();
        end
    end

endmodule

// ===== tb/drive_enable_sequencer_with_ramp_tb.sv =====
`timescale 1ns / 1ps

module drive_enable_sequencer_with_ramp_tb;

    localparam int MOTOR_COUNT = 7;

    typedef enum logic [2:0] {
        DRV_FAULT,
        DRV_DISABLED,
        DRV_READY,
        DRV_SWITCHED_ON,
        DRV_RUNNING
    } drive_stage_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             frame_valid  = 1'b0;
    logic             frame_ready;
    dsr_pkg::frame_t  frame        = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    dsr_pkg::result_t result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index    = dsr_pkg::CFG_RAMP_STEP_LARGE;
    logic [15:0]      cfg_data     = '0;
    int               fail_count;
    int               outstanding;

    bit                 calm = 1'b0;
    int                 links_this_cycle = 0;
    drive_stage_t       motor_stage [MOTOR_COUNT];
    logic signed [31:0] motor_pos [MOTOR_COUNT];
    logic signed [31:0] motor_goal [MOTOR_COUNT];

    drive_enable_sequencer_with_ramp #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    drive_enable_sequencer_with_ramp_checker #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("drive_enable_sequencer_with_ramp test failed");
        $finish;
    end

    // The receiver stalls once for a long stretch so that the block fills up.
    initial
    begin : result_sink
        int stall_left;
        int taken;
        bit held_once;
        stall_left = 0;
        taken      = 0;
        held_once  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                taken++;
            if (taken >= 400 && !held_once)
            begin
                held_once  = 1'b1;
                stall_left = 60;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= calm || ($urandom_range(99) >= 23);
            end
        end
    end

    function automatic dsr_pkg::frame_t make_frame(input logic [3:0] idx,
                                                   input logic [15:0] status,
                                                   input logic [31:0] act,
                                                   input logic [31:0] goal,
                                                   input logic link, input logic cend);
        dsr_pkg::frame_t f;
        f.motor_index       = idx;
        f.status_word       = status;
        f.measured_position = act;
        f.host_target       = goal;
        f.link_operational  = link;
        f.cycle_end         = cend;
        return f;
    endfunction

    function automatic logic [15:0] pick_status();
        logic [15:0] noise;
        noise = 16'($urandom) & ~dsr_pkg::STATUS_MASK;
        case ($urandom_range(5))
            0:       return dsr_pkg::ST_FAULT | noise;
            1:       return dsr_pkg::ST_DISABLED | noise;
            2:       return dsr_pkg::ST_READY | noise;
            3:       return dsr_pkg::ST_SWITCHED_ON | noise;
            4:       return dsr_pkg::ST_OP_ENABLED | noise;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic offer(input dsr_pkg::frame_t f);
        if (f.motor_index < MOTOR_COUNT && f.link_operational)
            links_this_cycle++;
        if (f.cycle_end)
            links_this_cycle = 0;
        while (!calm && $urandom_range(99) < 23)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= f;
        @(posedge clk);
        while (!frame_ready)
            @(posedge clk);
    endtask

    task automatic send_stray();
        offer(make_frame(4'($urandom_range(15, MOTOR_COUNT)), 16'($urandom), $urandom,
                         $urandom, 1'($urandom), 1'b0));
    endtask

    task automatic drain();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] step_hi, input logic [15:0] step_lo,
                                  input logic [4:0] group);
        drain();
        write_reg(dsr_pkg::CFG_RAMP_STEP_LARGE, step_hi);
        write_reg(dsr_pkg::CFG_RAMP_STEP_SMALL, step_lo);
        write_reg(dsr_pkg::CFG_LARGE_GROUP_COUNT, {11'($urandom), group});
        cfg_valid <= 1'b0;
    endtask

    task automatic drive_motor(input int m, input logic cend);
        logic [15:0] status;
        logic [15:0] noise;
        logic [31:0] act;
        int          roll;
        noise = ($urandom_range(1) != 0) ? (16'($urandom) & ~dsr_pkg::STATUS_MASK)
                                         : 16'h0000;
        roll  = $urandom_range(99);
        if (motor_stage[m] != DRV_RUNNING)
        begin
            if (roll < 5)
                motor_pos[m] = 32'sh7FFFFFFF;
            else if (roll < 10)
                motor_pos[m] = 32'sh80000000;
            else if (roll < 25)
                motor_pos[m] = $urandom;
            else
                motor_pos[m] = motor_pos[m] + 32'($urandom_range(400)) - 32'sd200;
            motor_goal[m] = motor_pos[m] + 32'($urandom_range(2000)) - 32'sd1000;
        end
        act = motor_pos[m];
        case (motor_stage[m])
            DRV_FAULT:
            begin
                status         = dsr_pkg::ST_FAULT;
                motor_stage[m] = DRV_DISABLED;
            end
            DRV_DISABLED:
            begin
                status = dsr_pkg::ST_DISABLED;
                if (roll < 80)
                    motor_stage[m] = DRV_READY;
            end
            DRV_READY:
            begin
                status = dsr_pkg::ST_READY;
                if (roll < 80)
                    motor_stage[m] = DRV_SWITCHED_ON;
            end
            DRV_SWITCHED_ON:
            begin
                status = dsr_pkg::ST_SWITCHED_ON;
                if (roll < 80)
                    motor_stage[m] = DRV_RUNNING;
            end
            default:
            begin
                status = dsr_pkg::ST_OP_ENABLED;
                act    = motor_pos[m] + 32'($urandom_range(64)) - 32'sd32;
                if (roll < 2)
                    motor_stage[m] = DRV_FAULT;
                else if (roll < 4)
                    motor_stage[m] = DRV_DISABLED;
                else if (roll < 7)
                    status = 16'($urandom);
                if (roll >= 90)
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5:
                            motor_goal[m] = motor_pos[m] + 32'($urandom_range(2000)) - 32'sd1000;
                        6, 7:
                            motor_goal[m] = $urandom;
                        default:
                            motor_goal[m] = motor_pos[m][31] ? 32'sh7FFFFFFF : 32'sh80000000;
                    endcase
                end
            end
        endcase
        offer(make_frame(4'(m), status | noise, act, motor_goal[m], 1'b1, cend));
    endtask

    task automatic run_bus_cycle();
        int order [MOTOR_COUNT];
        int pick;
        int j;
        int tmp;
        pick = $urandom_range(9);
        for (int k = 0; k < MOTOR_COUNT; k++)
            order[k] = k;
        if (pick == 7 || pick == 8)
        begin
            for (int k = MOTOR_COUNT - 1; k > 0; k--)
            begin
                j        = $urandom_range(k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        end
        else if (pick == 9)
        begin
            for (int k = 0; k < MOTOR_COUNT; k++)
                order[k] = $urandom_range(MOTOR_COUNT - 1);
        end
        for (int k = 0; k < MOTOR_COUNT; k++)
        begin
            if ($urandom_range(99) < 8)
                send_stray();
            drive_motor(order[k], k == MOTOR_COUNT - 1);
        end
    endtask

    task automatic run_phase(input int cycles);
        for (int c = 0; c < cycles; c++)
            run_bus_cycle();
    endtask

    initial
    begin : stimulus
        dsr_pkg::frame_t f;
        logic            cend;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            motor_stage[m] = DRV_DISABLED;
            motor_pos[m]   = '0;
            motor_goal[m]  = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(make_frame(4'd0, dsr_pkg::ST_FAULT, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0));
        offer(make_frame(4'd0, dsr_pkg::ST_DISABLED | 16'hFF90, 32'h80000000, 32'h0,
                         1'b1, 1'b0));
        offer(make_frame(4'd0, dsr_pkg::ST_READY, 32'hFFFFFFFF, 32'h0, 1'b1, 1'b0));
        offer(make_frame(4'd0, dsr_pkg::ST_SWITCHED_ON, 32'h7FFFFFFF, 32'h0, 1'b1, 1'b0));
        offer(make_frame(4'd0, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'h80000000, 1'b1, 1'b0));
        offer(make_frame(4'd0, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'h80000000, 1'b1, 1'b0));
        offer(make_frame(4'd0, dsr_pkg::ST_OP_ENABLED | 16'hFF90, 32'hFFFFFFFF,
                         32'h80000000, 1'b0, 1'b0));
        offer(make_frame(4'd1, dsr_pkg::ST_SWITCHED_ON, 32'h80000000, 32'h0, 1'b1, 1'b0));
        offer(make_frame(4'd1, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'h7FFFFFFF, 1'b1, 1'b0));
        offer(make_frame(4'd1, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'h7FFFFFFF, 1'b1, 1'b0));
        offer(make_frame(4'd5, dsr_pkg::ST_SWITCHED_ON, 32'd100, 32'h0, 1'b1, 1'b0));
        offer(make_frame(4'd5, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'd110, 1'b1, 1'b0));
        offer(make_frame(4'd5, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'd110, 1'b1, 1'b0));
        offer(make_frame(4'd5, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'd110, 1'b1, 1'b0));
        offer(make_frame(4'd5, dsr_pkg::ST_OP_ENABLED, 32'h0, -32'sd1000, 1'b1, 1'b0));
        offer(make_frame(4'd6, 16'h0000, 32'h0, 32'h0, 1'b1, 1'b0));
        offer(make_frame(4'd6, 16'hFFFF, 32'h5555AAAA, 32'hAAAA5555, 1'b1, 1'b0));
        offer(make_frame(4'd15, dsr_pkg::ST_OP_ENABLED, 32'h12345678, 32'h87654321,
                         1'b1, 1'b0));
        offer(make_frame(4'd7, dsr_pkg::ST_READY, 32'h0, 32'h0, 1'b1, 1'b1));
        offer(make_frame(4'd3, dsr_pkg::ST_FAULT, 32'h0, 32'h0, 1'b0, 1'b1));
        offer(make_frame(4'd2, dsr_pkg::ST_OP_ENABLED, 32'h0, 32'h0, 1'b1, 1'b0));
        offer(make_frame(4'd2, dsr_pkg::ST_OP_ENABLED, 32'h0, -32'sd5, 1'b1, 1'b0));

        write_settings(16'hFFFF, 16'h0000, 5'd3);

        // Before bring-up, cycles with missing or surplus links are harmless.
        for (int n = 0; n < 60; n++)
        begin
            if (n == 30)
            begin
                for (int k = 0; k < 35; k++)
                begin
                    offer(make_frame(4'($urandom_range(MOTOR_COUNT - 1)), pick_status(),
                                     $urandom, $urandom, 1'b1, 1'b0));
                end
            end
            f = make_frame(4'($urandom), pick_status(), $urandom, $urandom, 1'($urandom),
                           1'b0);
            cend = ($urandom_range(5) == 0);
            if (cend && links_this_cycle +
                ((f.motor_index < MOTOR_COUNT && f.link_operational) ? 1 : 0) == MOTOR_COUNT)
                cend = 1'b0;
            f.cycle_end = cend;
            offer(f);
        end
        if (links_this_cycle == MOTOR_COUNT)
            offer(make_frame(4'd0, pick_status(), $urandom, $urandom, 1'b1, 1'b0));
        offer(make_frame(4'd12, pick_status(), $urandom, $urandom, 1'($urandom), 1'b1));

        run_phase(1);
        run_phase(21);

        write_settings(16'h0000, 16'hFFFF, 5'd0);
        calm = 1'b1;
        run_phase(22);
        calm = 1'b0;

        write_settings(16'($urandom), 16'($urandom), 5'd16);
        run_phase(22);

        write_settings(16'($urandom_range(300)), 16'($urandom_range(300)),
                       5'($urandom_range(16)));
        run_phase(22);

        write_settings(16'd200, 16'd30, 5'd5);
        run_phase(22);

        write_settings(16'($urandom), 16'($urandom_range(100)), 5'($urandom_range(16)));
        run_phase(22);

        // One missing link latches the link loss; every later frame gets no position command.
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            offer(make_frame(4'(m), dsr_pkg::ST_OP_ENABLED, motor_pos[m], motor_goal[m],
                             m != 3, m == MOTOR_COUNT - 1));
        end
        for (int n = 0; n < 20; n++)
        begin
            offer(make_frame(4'($urandom), 16'($urandom), $urandom, $urandom, 1'($urandom),
                             1'($urandom)));
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("drive_enable_sequencer_with_ramp test passed");
        else
            $display("drive_enable_sequencer_with_ramp test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dsr_pkg.sv
design/dsr_drive.sv
design/dsr_link_mon.sv
design/drive_enable_sequencer_with_ramp.sv
tb/drive_enable_sequencer_with_ramp_checker.sv
tb/drive_enable_sequencer_with_ramp_tb.sv
